FILE: hdl/rsti_pkg.sv
// Package for the radix string-to-integer converter: widths, character codes,
// register indexes, scan phase type and the digit decoder.
// Depends on nothing; used by hdl/radix_string_to_integer.sv.
`default_nettype none

package rsti_pkg;

    localparam int CHAR_W    = 8;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int M_DATA_W  = 48;

    localparam logic [POS_W-1:0] STOP_CAP = 12'd4095;

    // character codes
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_7     = 8'h37;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_F     = 8'h66;
    localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

    // radix_mode codes; the unused code behaves as decimal
    localparam logic [1:0] RADIX_OCT = 2'd0;
    localparam logic [1:0] RADIX_DEC = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIX_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_BOUND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_BOUND = 2'd2;

    localparam logic signed [VALUE_W-1:0] LOWER_RESET = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] UPPER_RESET = 32'sh7fff_ffff;

    typedef enum logic [2:0] {
        PH_SKIP   = 3'b001,
        PH_DIGITS = 3'b010,
        PH_STOP   = 3'b100
    } phase_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } digit_t;

    function automatic digit_t digit_decode(input logic [CHAR_W-1:0] c,
                                            input logic [1:0] mode);
        logic [CHAR_W-1:0] lc;
        logic [CHAR_W-1:0] hex_val;
        digit_t d;
        lc      = c | CASE_BIT;
        hex_val = lc - CH_A + 8'd10;
        d.ok    = 1'b0;
        d.val   = 4'd0;
        if (c >= CH_0 && c <= CH_9) begin
            d.ok  = (mode != RADIX_OCT) || (c <= CH_7);
            d.val = c[3:0];
        end else if (mode == RADIX_HEX && lc >= CH_A && lc <= CH_F) begin
            d.ok  = 1'b1;
            d.val = hex_val[3:0];
        end
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/radix_string_to_integer.sv
// Top level of the radix string-to-integer converter: scan stage, end-of-string
// hold stage and bounds-check result register.
// Depends on hdl/rsti_pkg.sv.
//
//  Channel | Direction | Fields (low bit first)
//  --------+-----------+-----------------------------------------------------
//  s_      | in        | tdata: char_code[7:0]; tlast: end_of_string
//  m_      | out       | tdata: value[31:0], stop_position[43:32], zero pad;
//          |           | tuser: status
//  cfg_wr_ | in        | index 0 radix_mode, 1 lower_bound, 2 upper_bound
//
// One character per cycle while s_tready is high. A beat updates the scan registers;
// a beat with tlast moves the scan result into a hold stage, from which the checked
// result register is loaded once it is free; m_tvalid rises when it is loaded.
// Reset (aresetn low, synchronous) restores the registers and drops any pending
// result. With a stalled result and a full hold stage, s_tready drops for every
// character until m_tready frees the result register.
`default_nettype none

module radix_string_to_integer (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [rsti_pkg::CHAR_W-1:0]   s_tdata,   // char_code[7:0]
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [rsti_pkg::M_DATA_W-1:0]      m_tdata,   // value[31:0], stop_position[43:32]
    output logic                               m_tuser,   // status
    input  wire logic                          cfg_wr_en,
    input  wire logic [rsti_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [rsti_pkg::VALUE_W-1:0]  cfg_wr_data
);

    // configuration
    logic [1:0]                          radix_mode_reg;
    logic signed [rsti_pkg::VALUE_W-1:0] lower_bound_reg;
    logic signed [rsti_pkg::VALUE_W-1:0] upper_bound_reg;

    // scan state
    rsti_pkg::phase_t                    phase_reg, phase_next;
    logic [rsti_pkg::VALUE_W-1:0]        acc_reg, acc_next;
    logic                                neg_reg, neg_next;
    logic [rsti_pkg::POS_W-1:0]          idx_reg, idx_next;

    // hold stage
    logic                                fin_valid_reg;
    logic [rsti_pkg::VALUE_W-1:0]        fin_acc_reg;
    logic                                fin_neg_reg;
    logic [rsti_pkg::POS_W-1:0]          fin_idx_reg;

    // result register
    logic                                out_valid_reg;
    logic [rsti_pkg::VALUE_W-1:0]        out_value_reg;
    logic                                out_status_reg;
    logic [rsti_pkg::POS_W-1:0]          out_pos_reg;

    logic                                s_beat;
    logic                                out_free;
    logic                                fin_move;
    logic                                consumed;
    logic                                is_space;
    logic [rsti_pkg::VALUE_W-1:0]        acc_scaled;
    rsti_pkg::digit_t                    dig;
    logic signed [rsti_pkg::VALUE_W-1:0] signed_val;
    logic                                out_of_range;

    assign out_free = !out_valid_reg || m_tready;
    assign fin_move = fin_valid_reg && out_free;
    assign s_tready = aresetn && (!fin_valid_reg || out_free);
    assign s_beat   = s_tvalid && s_tready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_mode_reg  <= rsti_pkg::RADIX_DEC;
            lower_bound_reg <= rsti_pkg::LOWER_RESET;
            upper_bound_reg <= rsti_pkg::UPPER_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                rsti_pkg::REG_RADIX_MODE:  radix_mode_reg  <= cfg_wr_data[1:0];
                rsti_pkg::REG_LOWER_BOUND: lower_bound_reg <= cfg_wr_data;
                rsti_pkg::REG_UPPER_BOUND: upper_bound_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // scan logic: one character
    assign dig      = rsti_pkg::digit_decode(s_tdata, radix_mode_reg);
    assign is_space = (s_tdata == rsti_pkg::CH_SPACE) || (s_tdata == rsti_pkg::CH_TAB);

    always_comb begin
        unique case (radix_mode_reg)
            rsti_pkg::RADIX_OCT: acc_scaled = acc_reg << 3;
            rsti_pkg::RADIX_HEX: acc_scaled = acc_reg << 4;
            default:             acc_scaled = (acc_reg << 3) + (acc_reg << 1);
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        consumed   = 1'b0;
        unique case (phase_reg)
            rsti_pkg::PH_SKIP: begin
                if (is_space) begin
                    consumed = 1'b1;
                end else if (s_tdata == rsti_pkg::CH_MINUS) begin
                    consumed   = 1'b1;
                    neg_next   = 1'b1;
                    phase_next = rsti_pkg::PH_DIGITS;
                end else if (dig.ok) begin
                    consumed   = 1'b1;
                    acc_next   = acc_scaled + {{(rsti_pkg::VALUE_W-4){1'b0}}, dig.val};
                    phase_next = rsti_pkg::PH_DIGITS;
                end else begin
                    phase_next = rsti_pkg::PH_STOP;
                end
            end
            rsti_pkg::PH_DIGITS: begin
                if (dig.ok) begin
                    consumed = 1'b1;
                    acc_next = acc_scaled + {{(rsti_pkg::VALUE_W-4){1'b0}}, dig.val};
                end else begin
                    phase_next = rsti_pkg::PH_STOP;
                end
            end
            rsti_pkg::PH_STOP: ;
            default: ;
        endcase
        // saturate the position at the cap
        idx_next = (consumed && idx_reg != rsti_pkg::STOP_CAP) ? idx_reg + 1'b1 : idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= rsti_pkg::PH_SKIP;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            idx_reg   <= '0;
        end else if (s_beat) begin
            if (s_tlast) begin
                phase_reg <= rsti_pkg::PH_SKIP;
                acc_reg   <= '0;
                neg_reg   <= 1'b0;
                idx_reg   <= '0;
            end else begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                idx_reg   <= idx_next;
            end
        end
    end

    // hold stage: capture the finished scan of a last beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (s_beat && s_tlast) begin
            fin_valid_reg <= 1'b1;
        end else if (fin_move) begin
            fin_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat && s_tlast) begin
            fin_acc_reg <= acc_next;
            fin_neg_reg <= neg_next;
            fin_idx_reg <= idx_next;
        end
    end

    // sign and bounds check
    assign signed_val   = fin_neg_reg ? -$signed(fin_acc_reg) : $signed(fin_acc_reg);
    assign out_of_range = (signed_val < lower_bound_reg) || (signed_val > upper_bound_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fin_move) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_move) begin
            out_value_reg  <= out_of_range ? '0 : signed_val;
            out_status_reg <= out_of_range;
            out_pos_reg    <= fin_idx_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(rsti_pkg::M_DATA_W - rsti_pkg::VALUE_W - rsti_pkg::POS_W){1'b0}},
                       out_pos_reg, out_value_reg};

    // an out-of-range result carries a zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_status_reg |-> out_value_reg == '0)
        else $error("out-of-range result with nonzero value");

    // a last beat leaves the scan registers cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat && s_tlast |=> phase_reg == rsti_pkg::PH_SKIP && acc_reg == '0
                              && !neg_reg && idx_reg == '0)
        else $error("scan state not cleared after end of string");

    // while skipping whitespace nothing has been accumulated
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == rsti_pkg::PH_SKIP |-> acc_reg == '0 && !neg_reg)
        else $error("accumulator or sign set during whitespace skip");

    // a held result waits until the result register frees up
    assert property (@(posedge aclk) disable iff (!aresetn)
        fin_valid_reg && !out_free |=> fin_valid_reg)
        else $error("held result dropped while output stalled");

endmodule

`default_nettype wire
